// File: hdl/assert_macros.svh
// assertion macros, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPL(label, a, c)
`define ASSERT_NEXT(label, a, c)
`endif
`endif

// File: hdl/efd_pkg.sv
// ----------------------------------------------------------------------------
// efd_pkg
// shared types and constants of the flow detector
// ----------------------------------------------------------------------------
package efd_pkg;
	localparam int CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_MODE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_FIRST = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SECOND = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TPS = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_IDLE = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_INTERVAL = 3'd5;

	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_BYTES = 2'd1;
	localparam logic [1:0] MODE_LARGE = 2'd2;

	localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [6:0] AGED_MAX = 7'd127;
	localparam int KeyW = 120;

	typedef struct packed {
		logic [KeyW-1:0] key;
		logic [31:0] created;
		logic [31:0] last_used;
		logic [47:0] bytes;
		logic [31:0] large_cnt;
	} entry_t;
endpackage

// File: hdl/efd_table.sv
// ----------------------------------------------------------------------------
// efd_table
// flow entry memory, one read and one write port, registered read, valid bits in flops
// ----------------------------------------------------------------------------
module efd_table import efd_pkg::*; #(
	parameter int Entries = 64,
	parameter int IdxW = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [IdxW-1:0] rd_idx,
	output entry_t rd_data,
	output logic rd_valid,
	input  logic wr_en,
	input  logic [IdxW-1:0] wr_idx,
	input  entry_t wr_data,
	input  logic set_valid,
	input  logic clr_valid,
	input  logic [IdxW-1:0] vld_idx
);
	entry_t mem_q [Entries];
	logic [Entries-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		rd_data <= mem_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (set_valid) valid_q[vld_idx] <= 1'b1;
			if (clr_valid) valid_q[vld_idx] <= 1'b0;
			rd_valid <= valid_q[rd_idx];
		end
	end
endmodule

// File: hdl/elephant_flow_detector.sv
// ----------------------------------------------------------------------------
// elephant_flow_detector
// flow table that flags elephant flows and ages idle entries
// ----------------------------------------------------------------------------
// one item (packet or tick) is taken when start is high and busy low. a
// packet in a mode other than 0 walks every table entry through the single
// read port of the entry memory, then updates the matching or allocated
// entry, or none when the table is full and the key misses; a sweeping tick
// walks every entry likewise, while a plain tick or a packet in mode 0 walks
// none. the result is on the result ports for the one cycle that done is
// high and cannot be stalled. the mode 1 age limit
// ticks_per_second*second_threshold is formed once per accepted item on a
// single multiplier. configuration writes are always ready and are to be
// made while the block is idle.
module elephant_flow_detector import efd_pkg::*; #(
	parameter int Entries = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cmd,
	input  logic [31:0] src_address,
	input  logic [31:0] dst_address,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [7:0] protocol,
	input  logic [15:0] ingress_port,
	input  logic [15:0] packet_length,
	output logic done,
	output logic is_large_flow,
	output logic tracked,
	output logic [6:0] aged_out,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	`include "assert_macros.svh"

	localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;
	localparam int CntW = $clog2(Entries + 1);

	// sequencer states
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010, // issue reads over all entries
		ST_DRAIN = 7'b0000100, // last read data comes back
		ST_READ  = 7'b0001000, // fetch chosen entry
		ST_UPD   = 7'b0010000, // update entry and write back
		ST_JUDGE = 7'b0100000, // elephant test
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [1:0] mode_q;
	logic [31:0] first_q, second_q;
	logic [9:0] tps_q;
	logic [15:0] idle_q, interval_q;

	logic [31:0] now_q;
	logic [15:0] countdown_q;

	// item latched at start
	logic cmd_q;
	logic [KeyW-1:0] key_q;
	logic [15:0] len_q;

	// scan bookkeeping
	logic [CntW-1:0] rd_cnt_q;   // next address to read
	logic [IdxW-1:0] chk_idx_q;  // address of data now returned
	logic chk_live_q;            // returned data is a real read
	logic hit_q, free_q;
	logic [IdxW-1:0] hit_idx_q, free_idx_q;
	logic [6:0] aged_q;
	logic [41:0] limit_q;
	entry_t ent_q;
	logic large_q, tracked_q;

	entry_t rd_data, wr_data;
	logic rd_valid, wr_en, set_valid, clr_valid;
	logic [IdxW-1:0] rd_idx, wr_idx, vld_idx;
	logic [KeyW-1:0] in_key;

	assign in_key = {src_address, dst_address, src_port, dst_port, protocol, ingress_port};
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign rd_idx = (state_q == ST_READ) ? (hit_q ? hit_idx_q : free_idx_q)
		: rd_cnt_q[IdxW-1:0];

	// sweep: a returned valid entry whose idle age exceeds the life is dropped
	logic expire;
	assign expire = cmd_q && chk_live_q && rd_valid
		&& ((now_q - rd_data.last_used) > {16'd0, idle_q});

	// write back of the updated entry
	logic [47:0] bytes_sum;
	logic [48:0] bytes_wide;
	logic [31:0] lp_next;
	assign bytes_wide = {1'b0, rd_data.bytes} + {33'd0, len_q};
	always_comb begin
		entry_t base;
		base = rd_data;
		if (!hit_q) begin
			base.key = key_q;
			base.created = now_q;
			base.bytes = '0;
			base.large_cnt = '0;
		end
		bytes_sum = hit_q ? (bytes_wide[48] ? BYTES_MAX : bytes_wide[47:0])
			: {32'd0, len_q};
		lp_next = base.large_cnt;
		if (mode_q == MODE_LARGE && {16'd0, len_q} >= first_q && base.large_cnt != '1) begin
			lp_next = base.large_cnt + 32'd1;
		end
		wr_data = base;
		wr_data.last_used = now_q;
		wr_data.bytes = bytes_sum;
		wr_data.large_cnt = lp_next;
	end
	assign wr_en = (state_q == ST_UPD);
	assign wr_idx = hit_q ? hit_idx_q : free_idx_q;
	assign set_valid = wr_en && !hit_q;
	assign clr_valid = expire;
	assign vld_idx = expire ? chk_idx_q : wr_idx;

	efd_table #(.Entries(Entries), .IdxW(IdxW)) u_table (
		.clk, .arst_n, .rd_idx, .rd_data, .rd_valid, .wr_en, .wr_idx, .wr_data,
		.set_valid, .clr_valid, .vld_idx
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			first_q <= '0;
			second_q <= '0;
			tps_q <= 10'd100;
			idle_q <= 16'd500;
			interval_q <= 16'd100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_data[1:0];
				REG_FIRST: first_q <= cfg_data;
				REG_SECOND: second_q <= cfg_data;
				REG_TPS: tps_q <= cfg_data[9:0];
				REG_IDLE: idle_q <= cfg_data[15:0];
				REG_INTERVAL: interval_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			key_q <= in_key;
			len_q <= packet_length;
			limit_q <= {32'd0, tps_q} * {10'd0, second_q};
		end
		if (state_q == ST_UPD) ent_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q <= '0;
			countdown_q <= '0;
			cmd_q <= 1'b0;
			rd_cnt_q <= '0;
			chk_idx_q <= '0;
			chk_live_q <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
			aged_q <= '0;
			large_q <= 1'b0;
			tracked_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			chk_live_q <= (state_q == ST_SCAN);
			chk_idx_q <= rd_cnt_q[IdxW-1:0];
			// collect scan results from the returned read data
			if (chk_live_q && !cmd_q) begin
				if (rd_valid) begin
					if (!hit_q && rd_data.key == key_q) begin
						hit_q <= 1'b1;
						hit_idx_q <= chk_idx_q;
					end
				end else if (!free_q) begin
					free_q <= 1'b1;
					free_idx_q <= chk_idx_q;
				end
			end
			if (expire && aged_q != AGED_MAX) aged_q <= aged_q + 7'd1;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						rd_cnt_q <= '0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						aged_q <= '0;
						large_q <= 1'b0;
						tracked_q <= 1'b0;
						if (cmd) begin
							now_q <= now_q + 32'd1;
							if (countdown_q <= 16'd1) begin
								countdown_q <= (interval_q == '0) ? 16'd1 : interval_q;
								state_q <= ST_SCAN;
							end else begin
								countdown_q <= countdown_q - 16'd1;
								state_q <= ST_DONE;
							end
						end else begin
							state_q <= (mode_q == MODE_OFF) ? ST_DONE : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_cnt_q <= rd_cnt_q + CntW'(1);
					if (rd_cnt_q == CntW'(Entries - 1)) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= cmd_q ? ST_DONE : ST_READ;
				ST_READ: state_q <= (hit_q || free_q) ? ST_UPD : ST_DONE;
				ST_UPD: state_q <= ST_JUDGE;
				ST_JUDGE: begin
					tracked_q <= 1'b1;
					if (mode_q == MODE_BYTES) begin
						large_q <= (ent_q.bytes >= {16'd0, first_q})
							&& ({10'd0, now_q - ent_q.created} > limit_q);
					end else if (mode_q == MODE_LARGE) begin
						large_q <= ent_q.large_cnt >= second_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign is_large_flow = large_q;
	assign tracked = tracked_q;
	assign aged_out = aged_q;

	`ASSERT_NEXT(a_done_pulse, done, !done)
	`ASSERT_IMPL(a_tick_untracked, done && cmd_q, !tracked)
	`ASSERT_IMPL(a_packet_no_age, done && !cmd_q, aged_out == 7'd0)
	`ASSERT_IMPL(a_large_tracked, done && is_large_flow, tracked)
endmodule

// File: dv/elephant_flow_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elephant_flow_detector_tb
// self-checking bench: packets and ticks go in through start/busy, every done
// strobe is compared with a flow table model kept here, over several register
// settings that cover the byte test, the large-packet test, track-only mode,
// a full table and idle aging
// ----------------------------------------------------------------------------
module elephant_flow_detector_tb import efd_pkg::*; ();

	localparam int Entries = 64;
	localparam int CycleLimit = 2_000_000;
	localparam int SettleCycles = Entries + 16;
	localparam logic [1:0] MODE_TRACK = 2'd3;
	localparam logic CMD_PACKET = 1'b0;
	localparam logic CMD_TICK = 1'b1;
	localparam int PoolSize = 128;

	typedef struct packed {
		logic cmd;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0] proto;
		logic [15:0] inport;
		logic [15:0] len;
	} flow_item_t;

	typedef struct packed {
		logic elephant;
		logic tracked;
		logic [6:0] aged;
	} flow_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cmd = 1'b0;
	logic [31:0] src_address = '0;
	logic [31:0] dst_address = '0;
	logic [15:0] src_port = '0;
	logic [15:0] dst_port = '0;
	logic [7:0] protocol = '0;
	logic [15:0] ingress_port = '0;
	logic [15:0] packet_length = '0;
	logic done;
	logic is_large_flow;
	logic tracked;
	logic [6:0] aged_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	elephant_flow_detector #(.Entries(Entries)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the block's registers and flow table
	logic [1:0] m_mode;
	logic [31:0] m_first, m_second;
	logic [9:0] m_tps;
	logic [15:0] m_idle, m_interval;
	logic tbl_valid [Entries];
	logic [63:0] tbl_addrs [Entries];
	logic [31:0] tbl_ports [Entries];
	logic [23:0] tbl_pi [Entries];
	logic [31:0] tbl_created [Entries];
	logic [31:0] tbl_used [Entries];
	logic [47:0] tbl_bytes [Entries];
	logic [31:0] tbl_big [Entries];
	logic [31:0] now_ticks;
	logic [15:0] sweep_cd;

	flow_verdict_t verdict_q [$];
	flow_item_t key_pool [PoolSize];
	int errors = 0;
	int cycles = 0;
	int items_sent = 0;
	int n_elephant = 0, n_untracked = 0, n_aged = 0;
	bit gaps_on = 1'b1;

	// expected verdict of one item, advancing the model state
	function automatic flow_verdict_t predict_flow(input flow_item_t it);
		flow_verdict_t v;
		logic [63:0] addrs;
		logic [31:0] ports;
		logic [23:0] pi;
		logic [31:0] age;
		logic [63:0] age_limit;
		int hit, free_idx, n;
		v = '0;
		hit = -1;
		free_idx = -1;
		if (it.cmd == CMD_TICK) begin
			now_ticks = now_ticks + 32'd1;
			if (sweep_cd <= 16'd1) begin
				n = 0;
				for (int i = 0; i < Entries; i++) begin
					if (tbl_valid[i] && (now_ticks - tbl_used[i]) > {16'd0, m_idle}) begin
						tbl_valid[i] = 1'b0;
						if (n < 127) n++;
					end
				end
				v.aged = 7'(n);
				sweep_cd = (m_interval != 0) ? m_interval : 16'd1;
			end else begin
				sweep_cd = sweep_cd - 16'd1;
			end
			return v;
		end
		if (m_mode == MODE_OFF) return v;
		addrs = {it.src, it.dst};
		ports = {it.sport, it.dport};
		pi = {it.proto, it.inport};
		for (int i = 0; i < Entries; i++) begin
			if (tbl_valid[i]) begin
				if (hit < 0 && tbl_addrs[i] == addrs && tbl_ports[i] == ports && tbl_pi[i] == pi)
					hit = i;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (hit < 0) begin
			// table full: packet goes untracked
			if (free_idx < 0) return v;
			hit = free_idx;
			tbl_valid[hit] = 1'b1;
			tbl_addrs[hit] = addrs;
			tbl_ports[hit] = ports;
			tbl_pi[hit] = pi;
			tbl_created[hit] = now_ticks;
			tbl_bytes[hit] = '0;
			tbl_big[hit] = '0;
		end
		tbl_used[hit] = now_ticks;
		if (tbl_bytes[hit] > BYTES_MAX - 48'(it.len)) tbl_bytes[hit] = BYTES_MAX;
		else tbl_bytes[hit] = tbl_bytes[hit] + 48'(it.len);
		if (m_mode == MODE_LARGE && {16'd0, it.len} >= m_first && tbl_big[hit] != '1)
			tbl_big[hit] = tbl_big[hit] + 32'd1;
		if (m_mode == MODE_BYTES) begin
			age_limit = 64'(m_tps) * 64'(m_second);
			age = now_ticks - tbl_created[hit];
			v.elephant = (tbl_bytes[hit] >= 48'(m_first)) && (64'(age) > age_limit);
		end else if (m_mode == MODE_LARGE) begin
			v.elephant = tbl_big[hit] >= m_second;
		end
		v.tracked = 1'b1;
		return v;
	endfunction

	// result checker: the receiver cannot stall, so every done is taken
	always @(posedge clk) begin
		flow_verdict_t e;
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				e = verdict_q.pop_front();
				if (is_large_flow !== e.elephant) begin
					$error("is_large_flow: expected %0d, got %0d", e.elephant, is_large_flow);
					errors++;
				end
				if (tracked !== e.tracked) begin
					$error("tracked: expected %0d, got %0d", e.tracked, tracked);
					errors++;
				end
				if (aged_out !== e.aged) begin
					$error("aged_out: expected %0d, got %0d", e.aged, aged_out);
					errors++;
				end
				if (e.elephant) n_elephant++;
				if (e.aged != 0) n_aged++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("elephant_flow_detector_tb NOT OK");
			$finish;
		end
	end

	// one item: optional random gap, then hold start until busy is low at an edge
	task automatic send_item(input flow_item_t it);
		flow_verdict_t v;
		if (gaps_on && $urandom_range(99) < 19) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= it.cmd;
		src_address <= it.src;
		dst_address <= it.dst;
		src_port <= it.sport;
		dst_port <= it.dport;
		protocol <= it.proto;
		ingress_port <= it.inport;
		packet_length <= it.len;
		@(posedge clk);
		while (busy) @(posedge clk);
		v = predict_flow(it);
		if (it.cmd == CMD_PACKET && m_mode != MODE_OFF && !v.tracked) n_untracked++;
		verdict_q.push_back(v);
		items_sent++;
	endtask

	// stop sending, let every result arrive, then let a silent item finish
	task automatic drain;
		start <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// writes all six registers while the block is idle
	task automatic set_config(input logic [1:0] md, input logic [31:0] first,
			input logic [31:0] second, input logic [31:0] tps,
			input logic [31:0] idle, input logic [31:0] intv);
		logic [31:0] vals [6];
		logic [CfgIdxW-1:0] idx [6];
		vals = '{32'(md), first, second, tps, idle, intv};
		idx = '{REG_MODE, REG_FIRST, REG_SECOND, REG_TPS, REG_IDLE, REG_INTERVAL};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		m_mode = md;
		m_first = first;
		m_second = second;
		m_tps = tps[9:0];
		m_idle = idle[15:0];
		m_interval = intv[15:0];
	endtask

	function automatic flow_item_t pkt(input int key, input logic [15:0] len);
		flow_item_t it;
		it = key_pool[key];
		it.cmd = CMD_PACKET;
		it.len = len;
		return it;
	endfunction

	function automatic flow_item_t tick_item;
		flow_item_t it;
		it = '0;
		it.cmd = CMD_TICK;
		return it;
	endfunction

	// fresh random flow keys, two of them at the field extremes
	task automatic refill_pool;
		for (int i = 0; i < PoolSize; i++) begin
			key_pool[i] = '{CMD_PACKET, $urandom, $urandom, 16'($urandom), 16'($urandom),
				8'($urandom), 16'($urandom), 16'd0};
		end
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[1].cmd = CMD_PACKET;
	endtask

	// reset defaults: mode 0 ignores packets, first tick after reset sweeps
	task automatic test_reset_defaults;
		send_item(pkt(1, 16'hFFFF));
		send_item(pkt(0, 16'd0));
		send_item(tick_item());
		send_item(tick_item());
		drain();
	endtask

	// directed cases of each mode
	task automatic test_modes_directed;
		set_config(MODE_TRACK, 32'd0, 32'd0, 32'd1, 32'd2, 32'd1);
		send_item(pkt(0, 16'd0));
		send_item(pkt(1, 16'hFFFF));
		send_item(pkt(1, 16'hFFFF));   // hit on existing entry
		repeat (4) send_item(tick_item());   // sweep countdown still runs, no entry ages out
		drain();
		// byte test needs both volume and age
		set_config(MODE_BYTES, 32'd100, 32'd1, 32'd1, 32'd1000, 32'd1000);
		send_item(pkt(2, 16'd50));
		send_item(tick_item());
		send_item(pkt(2, 16'd30));
		send_item(tick_item());
		send_item(pkt(2, 16'd60));
		drain();
		// large-packet count: size boundary at first_threshold
		set_config(MODE_LARGE, 32'd1000, 32'd2, 32'd1, 32'd1000, 32'd1000);
		send_item(pkt(3, 16'd999));
		send_item(pkt(3, 16'd1000));
		send_item(pkt(3, 16'd1000));
		drain();
	endtask

	// fill every entry; the last keys of the loop miss and go untracked, then key 4 hits
	task automatic test_table_full;
		set_config(MODE_TRACK, 32'd0, 32'd0, 32'd100, 32'd65535, 32'd65535);
		for (int i = 0; i < Entries + 2; i++) send_item(pkt(i + 4, 16'($urandom)));
		send_item(pkt(4, 16'd1));
		drain();
		// short idle life and interval; these ticks only count down to the next sweep
		set_config(MODE_TRACK, 32'd0, 32'd0, 32'd100, 32'd1, 32'd1);
		repeat (3) send_item(tick_item());
		drain();
	endtask

	// random traffic over a pool of keys, ticks mixed in
	task automatic test_random_phase(input int n, input int pool, input int tick_pct);
		logic [15:0] len;
		int k;
		refill_pool();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < tick_pct) begin
				send_item(tick_item());
			end else begin
				k = $urandom_range(pool - 1);
				case ($urandom_range(9))
					0: len = 16'd0;
					1: len = 16'hFFFF;
					2, 3, 4: len = 16'($urandom);
					default: len = 16'($urandom_range(2000));
				endcase
				send_item(pkt(k, len));
			end
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < Entries; i++) tbl_valid[i] = 1'b0;
		m_mode = MODE_OFF;
		m_first = '0;
		m_second = '0;
		m_tps = 10'd100;
		m_idle = 16'd500;
		m_interval = 16'd100;
		now_ticks = '0;
		sweep_cd = '0;
		refill_pool();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_modes_directed();
		test_table_full();

		set_config(MODE_BYTES, 32'd5000, 32'd2, 32'd3, 32'd65535, 32'd65535);
		test_random_phase(250, 40, 25);
		set_config(MODE_LARGE, 32'd1000, 32'd3, 32'd1000, 32'd30, 32'd5);
		test_random_phase(250, 100, 20);
		set_config(MODE_TRACK, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1);
		test_random_phase(200, 90, 40);
		set_config(MODE_BYTES, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1000, 32'd200, 32'd10);
		test_random_phase(150, 50, 20);
		set_config(MODE_LARGE, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd20, 32'd3);
		test_random_phase(150, 70, 20);
		set_config(MODE_LARGE, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd20, 32'd3);
		test_random_phase(150, 70, 20);
		set_config(MODE_OFF, 32'h1234_5678, 32'd7, 32'd1000, 32'd10, 32'd2);
		test_random_phase(100, 60, 30);
		// out-of-range registers: zero ticks per second, zero interval
		set_config(MODE_BYTES, 32'd0, 32'd0, 32'd0, 32'd40, 32'd0);
		test_random_phase(200, 80, 20);
		// back-to-back stretch with no idle cycles at all
		gaps_on = 1'b0;
		set_config(MODE_LARGE, 32'd30000, 32'd2, 32'd10, 32'd60, 32'd7);
		test_random_phase(200, 80, 20);
		gaps_on = 1'b1;

		drain();
		$display("covered %0d items in all four modes, with table-full, aging and extreme registers",
			items_sent);
		$display("seen %0d elephant verdicts, %0d untracked packets, %0d sweeps that aged entries",
			n_elephant, n_untracked, n_aged);
		if (errors == 0) begin
			$display("elephant_flow_detector_tb OK");
		end else begin
			$display("elephant_flow_detector_tb NOT OK");
		end
		$finish;
	end
endmodule
